// ===== rtl/bka_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bka_pkg
// Shared types and constants of the button-to-key auto-repeat mapper.
// ----------------------------------------------------------------------------
package bka_pkg;

    localparam int MAP_DEPTH = 16;
    localparam int PAD_COUNT = 4;

    localparam int MAP_IW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int MAP_CW = $clog2(MAP_DEPTH + 1);
    localparam int PAD_IW = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;

    typedef enum logic [2:0] {
        OP_POLL    = 3'd0,
        OP_ADD     = 3'd1,
        OP_REM_BTN = 3'd2,
        OP_REM_KEY = 3'd3,
        OP_CLEAR   = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        KIND_DOWN = 2'd0,
        KIND_UP   = 2'd1,
        KIND_DONE = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_EXISTS = 2'd1,
        STAT_FULL   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } t_state;

    // register index (paddr[2])
    localparam logic REG_EVENTS_ENABLE = 1'b0;

    localparam logic [31:0] MSG_DOWN      = 32'h00ff_0001;
    localparam logic [31:0] MSG_UP        = 32'hc0ff_0001;
    localparam logic [31:0] MSG_PREV_DOWN = 32'h4000_0000;

    typedef struct packed {
        logic [1:0]  ctl;
        logic [15:0] button;
        logic [7:0]  key;
        logic [15:0] period;
        logic [31:0] last_press;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

    // per-item context seen by the slot evaluator
    typedef struct packed {
        logic [1:0]  ctl;
        logic [15:0] pad;
        logic [31:0] now;
        logic [15:0] mbtn;
        logic [7:0]  key;
        logic [15:0] prev_btn;
        logic        adv;
        logic        disp;
    } t_scan;

    typedef struct packed {
        logic        sel;
        logic        btn_hit;
        logic        key_hit;
        logic        emit;
        logic        is_down;
        logic [31:0] msg;
        logic [31:0] new_lp;
    } t_eval;

endpackage

// ===== rtl/button_to_key_autorepeat.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_to_key_autorepeat
// Maps controller buttons to key events with auto-repeat, over a slot table.
// ----------------------------------------------------------------------------
// One word at a time. A table op (add, remove by button, remove by key,
// clear) and a poll that dispatches walk every slot through one evaluation
// unit fed by the slot RAM read port, pipelined one deep behind the read,
// one slot per cycle while no event word waits on the output, and then
// load the done word. A poll that does not dispatch, and an unknown op,
// skip the scan and go straight to the done word. Key events come out in
// slot order, and each input ends with one done word (last = 1). The input
// is not ready until that done word has been loaded. No clearing pass after
// reset: slot and pad valid bits reset in flops.
module button_to_key_autorepeat (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB-style configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_op,
    input  logic [1:0]  i_controller,
    input  logic        i_connected,
    input  logic [15:0] i_pad_buttons,
    input  logic [31:0] i_packet_number,
    input  logic [31:0] i_tick_now,
    input  logic [15:0] i_mapped_button,
    input  logic [7:0]  i_key_code,
    input  logic [15:0] i_repeat_period,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_key_out,
    output logic [31:0] o_message_word,
    output logic [1:0]  o_status,
    output logic        o_connected_out,
    output logic        o_last
);

    localparam int MAP_DEPTH = bka_pkg::MAP_DEPTH;
    localparam int PAD_COUNT = bka_pkg::PAD_COUNT;
    localparam int MAP_IW    = bka_pkg::MAP_IW;
    localparam int MAP_CW    = bka_pkg::MAP_CW;
    localparam int PAD_IW    = bka_pkg::PAD_IW;

    // control state
    bka_pkg::t_state        r_state, n_state;
    logic                   r_en;
    logic [MAP_DEPTH-1:0]   r_valid, n_valid;
    logic [PAD_COUNT-1:0]   r_present, n_present;
    logic [MAP_CW-1:0]      r_idx, n_idx;
    logic                   r_ev_vld, n_ev_vld;
    logic                   r_out_vld, n_out_vld;

    // item and scan payload
    logic [2:0]             r_op, n_op;
    logic [1:0]             r_ctl, n_ctl;
    logic                   r_conn, n_conn;
    logic                   r_inrange, n_inrange;
    logic [15:0]            r_pad, n_pad;
    logic [31:0]            r_pkt, n_pkt;
    logic [31:0]            r_now, n_now;
    logic [15:0]            r_mbtn, n_mbtn;
    logic [7:0]             r_key, n_key;
    logic [15:0]            r_per, n_per;
    logic [15:0]            r_prev_sel, n_prev_sel;
    logic                   r_adv, n_adv;
    logic                   r_disp, n_disp;
    logic [MAP_IW-1:0]      r_ev_idx, n_ev_idx;
    logic                   r_found, n_found;
    logic                   r_free_found, n_free_found;
    logic [MAP_IW-1:0]      r_free_idx, n_free_idx;
    logic [15:0]            r_prev_btn [PAD_COUNT];
    logic [15:0]            n_prev_btn [PAD_COUNT];
    logic [31:0]            r_prev_pkt [PAD_COUNT];
    logic [31:0]            n_prev_pkt [PAD_COUNT];

    // output word
    bka_pkg::t_kind         r_kind, n_kind;
    logic [7:0]             r_key_out, n_key_out;
    logic [31:0]            r_msg, n_msg;
    bka_pkg::t_status       r_status, n_status;
    logic                   r_conn_out, n_conn_out;
    logic                   r_last, n_last;

    // slot RAM
    logic                   ram_we;
    logic [MAP_IW-1:0]      ram_waddr;
    bka_pkg::t_slot         ram_wdata;
    logic                   ram_re;
    logic [bka_pkg::SLOT_W-1:0] ram_rdata;
    bka_pkg::t_slot         rd_slot;

    bka_pkg::t_scan         ctx;
    bka_pkg::t_eval         ev;

    logic [PAD_IW-1:0]      in_pidx;
    logic [PAD_IW-1:0]      pidx;
    logic                   in_range;
    logic                   in_disp;
    logic                   need_scan;
    logic                   out_free;
    logic                   issue;
    logic                   advance;
    logic                   cfg_wr;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == bka_pkg::REG_EVENTS_ENABLE);
    assign prdata = (paddr[2] == bka_pkg::REG_EVENTS_ENABLE) ? {31'd0, r_en} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en <= 1'b0;
        end else if (cfg_wr) begin
            r_en <= pwdata[0];
        end
    end

    // ---------------- slot table ----------------
    bka_ram #(
        .WIDTH (bka_pkg::SLOT_W),
        .DEPTH (MAP_DEPTH)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_idx[MAP_IW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign rd_slot = bka_pkg::t_slot'(ram_rdata);

    always_comb begin
        ctx.ctl      = r_ctl;
        ctx.pad      = r_pad;
        ctx.now      = r_now;
        ctx.mbtn     = r_mbtn;
        ctx.key      = r_key;
        ctx.prev_btn = r_prev_sel;
        ctx.adv      = r_adv;
        ctx.disp     = r_disp;
    end

    bka_slot_eval u_eval (
        .i_slot       (rd_slot),
        .i_slot_valid (r_valid[r_ev_idx]),
        .i_ctx        (ctx),
        .o_eval       (ev)
    );

    // ---------------- sequencer ----------------
    assign in_pidx  = i_controller[PAD_IW-1:0];
    assign pidx     = r_ctl[PAD_IW-1:0];
    assign in_range = {1'b0, i_controller} < 3'(PAD_COUNT);
    assign in_disp  = (i_op == bka_pkg::OP_POLL) && in_range && i_connected && r_en
                      && r_present[in_pidx];
    assign out_free = !r_out_vld || i_out_ready;
    assign issue    = (r_idx != MAP_CW'(MAP_DEPTH));
    // an event word may only leave the eval stage into a free output register
    assign advance  = !(r_ev_vld && ev.emit && !out_free);
    assign o_in_ready = (r_state == bka_pkg::S_IDLE);

    always_comb begin
        unique case (i_op) inside
            bka_pkg::OP_POLL: need_scan = in_disp;
            bka_pkg::OP_ADD, bka_pkg::OP_REM_BTN, bka_pkg::OP_REM_KEY,
            bka_pkg::OP_CLEAR: need_scan = 1'b1;
            default: need_scan = 1'b0;
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_valid      = r_valid;
        n_present    = r_present;
        n_idx        = r_idx;
        n_ev_vld     = r_ev_vld;
        n_out_vld    = r_out_vld;
        n_op         = r_op;
        n_ctl        = r_ctl;
        n_conn       = r_conn;
        n_inrange    = r_inrange;
        n_pad        = r_pad;
        n_pkt        = r_pkt;
        n_now        = r_now;
        n_mbtn       = r_mbtn;
        n_key        = r_key;
        n_per        = r_per;
        n_prev_sel   = r_prev_sel;
        n_adv        = r_adv;
        n_disp       = r_disp;
        n_ev_idx     = r_ev_idx;
        n_found      = r_found;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_prev_btn   = r_prev_btn;
        n_prev_pkt   = r_prev_pkt;
        n_kind       = r_kind;
        n_key_out    = r_key_out;
        n_msg        = r_msg;
        n_status     = r_status;
        n_conn_out   = r_conn_out;
        n_last       = r_last;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_waddr    = r_ev_idx;
        ram_wdata    = rd_slot;
        ram_wdata.last_press = ev.new_lp;

        if (r_out_vld && i_out_ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            bka_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_op         = i_op;
                    n_ctl        = i_controller;
                    n_conn       = i_connected;
                    n_inrange    = in_range;
                    n_pad        = i_pad_buttons;
                    n_pkt        = i_packet_number;
                    n_now        = i_tick_now;
                    n_mbtn       = i_mapped_button;
                    n_key        = i_key_code;
                    n_per        = i_repeat_period;
                    n_prev_sel   = r_prev_btn[in_pidx];
                    n_adv        = r_prev_pkt[in_pidx] < i_packet_number;
                    n_disp       = in_disp;
                    n_idx        = '0;
                    n_ev_vld     = 1'b0;
                    n_found      = 1'b0;
                    n_free_found = 1'b0;
                    n_state      = need_scan ? bka_pkg::S_SCAN : bka_pkg::S_FIN;
                end
            end
            bka_pkg::S_SCAN: begin
                if (!issue && !r_ev_vld) begin
                    n_state = bka_pkg::S_FIN;
                end else if (advance) begin
                    if (issue) begin
                        ram_re = 1'b1;
                        n_idx  = r_idx + MAP_CW'(1);
                    end
                    n_ev_vld = issue;
                    n_ev_idx = r_idx[MAP_IW-1:0];
                    if (r_ev_vld) begin
                        unique case (r_op)
                            bka_pkg::OP_POLL: begin
                                if (ev.emit) begin
                                    ram_we     = 1'b1;
                                    n_out_vld  = 1'b1;
                                    n_kind     = ev.is_down ? bka_pkg::KIND_DOWN
                                                            : bka_pkg::KIND_UP;
                                    n_key_out  = rd_slot.key;
                                    n_msg      = ev.msg;
                                    n_status   = bka_pkg::STAT_OK;
                                    n_conn_out = 1'b0;
                                    n_last     = 1'b0;
                                end
                            end
                            bka_pkg::OP_ADD: begin
                                if (ev.btn_hit) begin
                                    n_found = 1'b1;
                                end
                                if (!r_valid[r_ev_idx] && !r_free_found) begin
                                    n_free_found = 1'b1;
                                    n_free_idx   = r_ev_idx;
                                end
                            end
                            bka_pkg::OP_REM_BTN: begin
                                if (ev.btn_hit && !r_found) begin
                                    n_found           = 1'b1;
                                    n_valid[r_ev_idx] = 1'b0;
                                end
                            end
                            bka_pkg::OP_REM_KEY: begin
                                if (ev.key_hit && !r_found) begin
                                    n_found           = 1'b1;
                                    n_valid[r_ev_idx] = 1'b0;
                                end
                            end
                            bka_pkg::OP_CLEAR: begin
                                if (ev.sel) begin
                                    n_valid[r_ev_idx] = 1'b0;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            bka_pkg::S_FIN: begin
                if (out_free) begin
                    n_out_vld  = 1'b1;
                    n_kind     = bka_pkg::KIND_DONE;
                    n_key_out  = 8'd0;
                    n_msg      = 32'd0;
                    n_status   = bka_pkg::STAT_OK;
                    n_conn_out = 1'b0;
                    n_last     = 1'b1;
                    if (r_op == bka_pkg::OP_POLL) begin
                        n_conn_out = r_conn;
                        if (r_inrange) begin
                            n_present[pidx] = r_conn;
                            if (r_conn) begin
                                n_prev_btn[pidx] = r_pad;
                                n_prev_pkt[pidx] = r_pkt;
                            end
                        end
                    end
                    if (r_op == bka_pkg::OP_ADD) begin
                        if (r_found) begin
                            n_status = bka_pkg::STAT_EXISTS;
                        end else if (r_free_found) begin
                            ram_we               = 1'b1;
                            ram_waddr            = r_free_idx;
                            ram_wdata.ctl        = r_ctl;
                            ram_wdata.button     = r_mbtn;
                            ram_wdata.key        = r_key;
                            ram_wdata.period     = r_per;
                            ram_wdata.last_press = 32'd0;
                            n_valid[r_free_idx]  = 1'b1;
                        end else begin
                            n_status = bka_pkg::STAT_FULL;
                        end
                    end
                    n_state = bka_pkg::S_IDLE;
                end
            end
            default: n_state = bka_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= bka_pkg::S_IDLE;
            r_valid   <= '0;
            r_present <= '0;
            r_idx     <= '0;
            r_ev_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_present <= n_present;
            r_idx     <= n_idx;
            r_ev_vld  <= n_ev_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_ctl        <= n_ctl;
        r_conn       <= n_conn;
        r_inrange    <= n_inrange;
        r_pad        <= n_pad;
        r_pkt        <= n_pkt;
        r_now        <= n_now;
        r_mbtn       <= n_mbtn;
        r_key        <= n_key;
        r_per        <= n_per;
        r_prev_sel   <= n_prev_sel;
        r_adv        <= n_adv;
        r_disp       <= n_disp;
        r_ev_idx     <= n_ev_idx;
        r_found      <= n_found;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
        r_prev_btn   <= n_prev_btn;
        r_prev_pkt   <= n_prev_pkt;
        r_kind       <= n_kind;
        r_key_out    <= n_key_out;
        r_msg        <= n_msg;
        r_status     <= n_status;
        r_conn_out   <= n_conn_out;
        r_last       <= n_last;
    end

    assign o_out_valid     = r_out_vld;
    assign o_kind          = r_kind;
    assign o_key_out       = r_key_out;
    assign o_message_word  = r_msg;
    assign o_status        = r_status;
    assign o_connected_out = r_conn_out;
    assign o_last          = r_last;

    // ---------------- assertions ----------------
    a_ev_only_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ev_vld |-> (r_state == bka_pkg::S_SCAN))
        else $error("eval stage busy outside scan");

    a_event_needs_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> r_disp)
        else $error("key event from a poll that does not dispatch");

    a_done_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bka_pkg::S_FIN && n_state == bka_pkg::S_IDLE)
        |=> (o_out_valid && o_last))
        else $error("done word missing at end of item");

    a_scan_write_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && r_state == bka_pkg::S_SCAN) |-> (r_ev_vld && ram_waddr == r_ev_idx))
        else $error("slot write away from the evaluated slot");

endmodule

// ===== rtl/bka_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bka_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bka_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/bka_slot_eval.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bka_slot_eval
// Evaluates one mapping slot: ownership and lookup matches, and the press /
// release decision with its message word and new last-press tick.
// ----------------------------------------------------------------------------
module bka_slot_eval (
    input  bka_pkg::t_slot i_slot,
    input  logic           i_slot_valid,
    input  bka_pkg::t_scan i_ctx,
    output bka_pkg::t_eval o_eval
);

    logic        sel;
    logic        was;
    logic        pressed;
    logic        lp_zero;
    logic [31:0] elapsed;
    logic        fire;
    logic        down;
    logic        up;

    always_comb begin
        sel     = i_slot_valid && (i_slot.ctl == i_ctx.ctl);
        was     = (i_ctx.prev_btn & i_slot.button) != 16'd0;
        pressed = (i_ctx.pad & i_slot.button) != 16'd0;
        lp_zero = (i_slot.last_press == 32'd0);
        // wrapping tick difference
        elapsed = i_ctx.now - i_slot.last_press;
        fire    = ((i_slot.period != 16'd0) && (elapsed >= {16'd0, i_slot.period}))
                  || ((i_slot.period == 16'd0) && !was) || lp_zero;
        down    = i_ctx.disp && sel && pressed && fire;
        up      = i_ctx.disp && sel && !pressed && i_ctx.adv && !lp_zero;

        o_eval.sel     = sel;
        o_eval.btn_hit = sel && (i_slot.button == i_ctx.mbtn);
        o_eval.key_hit = sel && (i_slot.key == i_ctx.key);
        o_eval.emit    = down || up;
        o_eval.is_down = down;
        o_eval.msg     = down ? (bka_pkg::MSG_DOWN | (was ? bka_pkg::MSG_PREV_DOWN : 32'd0))
                              : bka_pkg::MSG_UP;
        o_eval.new_lp  = down ? i_ctx.now : 32'd0;
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the button-to-key auto-repeat mapper.
// ----------------------------------------------------------------------------
// A queue of table ops and controller polls feeds a valid/ready driver. On
// every accepted word a behavioral copy of the slot table and pad history
// predicts the key-down, key-up and done words. A monitor checks each output
// word against the oldest prediction. The run covers directed corner cases,
// then three random phases at both events_enable settings.
module testbench;

    localparam int          CYCLE_LIMIT     = 200000;
    localparam int          TAIL_CYCLES     = 2 * (bka_pkg::MAP_DEPTH + 3);
    localparam logic [2:0]  OP_FIRST_UNUSED = 3'd5;
    localparam logic [2:0]  OP_LAST_UNUSED  = 3'd7;

    typedef struct packed {
        logic [2:0]  op;
        logic [1:0]  ctl;
        logic        conn;
        logic [15:0] pad;
        logic [31:0] pkt;
        logic [31:0] tick;
        logic [15:0] mbtn;
        logic [7:0]  key;
        logic [15:0] per;
    } t_cmd;

    typedef struct packed {
        bka_pkg::t_kind   kind;
        logic [7:0]       key;
        logic [31:0]      msg;
        bka_pkg::t_status status;
        logic             conn;
        logic             last;
    } t_key_word;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid  = 1'b0;
    logic        out_ready = 1'b0;
    t_cmd        req       = '0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [1:0]  o_kind;
    logic [7:0]  o_key_out;
    logic [31:0] o_message_word;
    logic [1:0]  o_status;
    logic        o_connected_out;
    logic        o_last;

    t_cmd      cmd_q[$];
    t_key_word owed_words[$];

    // mapper state as predicted (bit types start at zero)
    bit        map_valid [bka_pkg::MAP_DEPTH];
    bit [1:0]  map_ctl   [bka_pkg::MAP_DEPTH];
    bit [15:0] map_btn   [bka_pkg::MAP_DEPTH];
    bit [7:0]  map_key   [bka_pkg::MAP_DEPTH];
    bit [15:0] map_per   [bka_pkg::MAP_DEPTH];
    bit [31:0] map_last  [bka_pkg::MAP_DEPTH];
    bit        pad_seen     [bka_pkg::PAD_COUNT];
    bit [15:0] pad_prev_btn [bka_pkg::PAD_COUNT];
    bit [31:0] pad_prev_pkt [bka_pkg::PAD_COUNT];
    bit        ev_enable;

    // stimulus-side pad history
    bit [31:0] gen_tick [4];
    bit [31:0] gen_pkt  [4];

    int idle_pct = 13;
    int cycles   = 0;
    int errors   = 0;
    int n_in     = 0;
    int n_down   = 0;
    int n_up     = 0;
    int n_done   = 0;
    int n_full   = 0;
    int n_exists = 0;
    int n_cfg    = 0;

    button_to_key_autorepeat u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (in_valid),
        .o_in_ready      (o_in_ready),
        .i_op            (req.op),
        .i_controller    (req.ctl),
        .i_connected     (req.conn),
        .i_pad_buttons   (req.pad),
        .i_packet_number (req.pkt),
        .i_tick_now      (req.tick),
        .i_mapped_button (req.mbtn),
        .i_key_code      (req.key),
        .i_repeat_period (req.per),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .o_kind          (o_kind),
        .o_key_out       (o_key_out),
        .o_message_word  (o_message_word),
        .o_status        (o_status),
        .o_connected_out (o_connected_out),
        .o_last          (o_last)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_key_word key_word(input bka_pkg::t_kind kind,
                                           input logic [7:0] key,
                                           input logic [31:0] msg,
                                           input bka_pkg::t_status st,
                                           input logic conn, input logic last);
        t_key_word w;
        w.kind   = kind;
        w.key    = key;
        w.msg    = msg;
        w.status = st;
        w.conn   = conn;
        w.last   = last;
        return w;
    endfunction

    // lowest valid slot of the controller matching the button, or the key
    function automatic int find_slot(input bit [1:0] ctl, input bit by_key,
                                     input bit [15:0] btn, input bit [7:0] key);
        for (int i = 0; i < bka_pkg::MAP_DEPTH; i++) begin
            if (map_valid[i] && map_ctl[i] == ctl &&
                (by_key ? map_key[i] == key : map_btn[i] == btn))
                return i;
        end
        return -1;
    endfunction

    task automatic compute_key_words(input t_cmd c);
        int               idx;
        bit               has_map;
        bit               advanced;
        bit               was;
        bit               fire;
        bit [15:0]        prev;
        bit [31:0]        elapsed;
        bka_pkg::t_status st;
        st = bka_pkg::STAT_OK;
        case (c.op)
            bka_pkg::OP_POLL: begin
                if (c.ctl < bka_pkg::PAD_COUNT) begin
                    if (c.conn) begin
                        has_map = 1'b0;
                        for (int i = 0; i < bka_pkg::MAP_DEPTH; i++)
                            if (map_valid[i] && map_ctl[i] == c.ctl)
                                has_map = 1'b1;
                        if (ev_enable && has_map && pad_seen[c.ctl]) begin
                            prev     = pad_prev_btn[c.ctl];
                            advanced = pad_prev_pkt[c.ctl] < c.pkt;
                            for (int i = 0; i < bka_pkg::MAP_DEPTH; i++) begin
                                if (!map_valid[i] || map_ctl[i] != c.ctl)
                                    continue;
                                was = (prev & map_btn[i]) != 0;
                                if ((c.pad & map_btn[i]) != 0) begin
                                    elapsed = c.tick - map_last[i];
                                    fire = (map_per[i] != 0 && elapsed >= map_per[i]) ||
                                           (map_per[i] == 0 && !was) || map_last[i] == 0;
                                    if (fire) begin
                                        map_last[i] = c.tick;
                                        owed_words.push_back(key_word(bka_pkg::KIND_DOWN,
                                            map_key[i],
                                            bka_pkg::MSG_DOWN |
                                            (was ? bka_pkg::MSG_PREV_DOWN : 32'h0),
                                            bka_pkg::STAT_OK, 1'b0, 1'b0));
                                    end
                                end else if (advanced && map_last[i] != 0) begin
                                    map_last[i] = '0;
                                    owed_words.push_back(key_word(bka_pkg::KIND_UP,
                                        map_key[i], bka_pkg::MSG_UP, bka_pkg::STAT_OK,
                                        1'b0, 1'b0));
                                end
                            end
                        end
                        pad_seen[c.ctl]     = 1'b1;
                        pad_prev_btn[c.ctl] = c.pad;
                        pad_prev_pkt[c.ctl] = c.pkt;
                    end else begin
                        pad_seen[c.ctl] = 1'b0;
                    end
                end
            end
            bka_pkg::OP_ADD: begin
                if (find_slot(c.ctl, 1'b0, c.mbtn, c.key) >= 0) begin
                    st = bka_pkg::STAT_EXISTS;
                    n_exists++;
                end else begin
                    st = bka_pkg::STAT_FULL;
                    for (int i = 0; i < bka_pkg::MAP_DEPTH; i++) begin
                        if (!map_valid[i]) begin
                            map_valid[i] = 1'b1;
                            map_ctl[i]   = c.ctl;
                            map_btn[i]   = c.mbtn;
                            map_key[i]   = c.key;
                            map_per[i]   = c.per;
                            map_last[i]  = '0;
                            st = bka_pkg::STAT_OK;
                            break;
                        end
                    end
                    if (st == bka_pkg::STAT_FULL)
                        n_full++;
                end
            end
            bka_pkg::OP_REM_BTN: begin
                idx = find_slot(c.ctl, 1'b0, c.mbtn, c.key);
                if (idx >= 0)
                    map_valid[idx] = 1'b0;
            end
            bka_pkg::OP_REM_KEY: begin
                idx = find_slot(c.ctl, 1'b1, c.mbtn, c.key);
                if (idx >= 0)
                    map_valid[idx] = 1'b0;
            end
            bka_pkg::OP_CLEAR: begin
                for (int i = 0; i < bka_pkg::MAP_DEPTH; i++)
                    if (map_valid[i] && map_ctl[i] == c.ctl)
                        map_valid[i] = 1'b0;
            end
            default: ;
        endcase
        owed_words.push_back(key_word(bka_pkg::KIND_DONE, 8'h00, 32'h0, st,
                                      (c.op == bka_pkg::OP_POLL) ? c.conn : 1'b0, 1'b1));
    endtask

    // poll with random don't-care mapping fields
    function automatic t_cmd poll_cmd(input logic [1:0] ctl, input logic conn,
                                      input logic [15:0] pad, input logic [31:0] pkt,
                                      input logic [31:0] tick);
        t_cmd c;
        c.op   = bka_pkg::OP_POLL;
        c.ctl  = ctl;
        c.conn = conn;
        c.pad  = pad;
        c.pkt  = pkt;
        c.tick = tick;
        c.mbtn = 16'($urandom);
        c.key  = 8'($urandom);
        c.per  = 16'($urandom);
        return c;
    endfunction

    // table op with random don't-care poll fields
    function automatic t_cmd map_cmd(input logic [2:0] op, input logic [1:0] ctl,
                                     input logic [15:0] btn, input logic [7:0] key,
                                     input logic [15:0] per);
        t_cmd c;
        c.op   = op;
        c.ctl  = ctl;
        c.conn = 1'($urandom);
        c.pad  = 16'($urandom);
        c.pkt  = $urandom;
        c.tick = $urandom;
        c.mbtn = btn;
        c.key  = key;
        c.per  = per;
        return c;
    endfunction

    function automatic t_cmd rand_cmd();
        int          sel;
        int          roll;
        logic [1:0]  c;
        logic [15:0] btn;
        logic [15:0] per;
        logic [15:0] pad;
        logic [7:0]  key;
        sel  = $urandom_range(0, 99);
        roll = $urandom_range(0, 99);
        c    = 2'($urandom_range(0, 3));
        // buttons and keys mostly from a small pool so later ops hit them
        if (roll < 80)
            btn = 16'h0001 << $urandom_range(0, 5);
        else if (roll < 90)
            btn = (16'h0001 << $urandom_range(0, 5)) | (16'h0001 << $urandom_range(0, 5));
        else
            btn = 16'($urandom);
        key = ($urandom_range(0, 99) < 8) ? 8'($urandom) : 8'($urandom_range(0, 15));
        if (roll < 30)
            per = '0;
        else if (roll < 85)
            per = 16'($urandom_range(1, 200));
        else if (roll < 95)
            per = 16'($urandom);
        else
            per = 16'h0001;
        if (sel < 55) begin
            pad = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom & 16'h003f);
            if ($urandom_range(0, 99) < 5)
                gen_pkt[c] = $urandom;
            else
                gen_pkt[c] += $urandom_range(0, 2);
            gen_tick[c] += $urandom_range(0, 250);
            if ($urandom_range(0, 99) < 2)
                gen_tick[c] = '0;
            return poll_cmd(c, $urandom_range(0, 99) >= 6, pad, gen_pkt[c], gen_tick[c]);
        end
        if (sel < 75)
            return map_cmd(bka_pkg::OP_ADD, c, btn, key, per);
        if (sel < 83)
            return map_cmd(bka_pkg::OP_REM_BTN, c, btn, key, per);
        if (sel < 90)
            return map_cmd(bka_pkg::OP_REM_KEY, c, btn, key, per);
        if (sel < 95)
            return map_cmd(bka_pkg::OP_CLEAR, c, btn, key, per);
        return map_cmd(3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED)), c, btn, key, per);
    endfunction

    task automatic queue_random(input int count, input bit with_fill);
        logic [1:0] c;
        for (int k = 0; k < count; k++) begin
            if (with_fill && k == count / 2) begin
                // overfill the table, poll it, then empty it
                for (int j = 0; j < bka_pkg::MAP_DEPTH + 1; j++)
                    cmd_q.push_back(map_cmd(bka_pkg::OP_ADD, 2'($urandom_range(0, 3)),
                                            16'($urandom), 8'($urandom), 16'($urandom)));
                for (int j = 0; j < 6; j++) begin
                    c = 2'($urandom_range(0, 3));
                    gen_pkt[c]  += 1;
                    gen_tick[c] += $urandom_range(0, 250);
                    cmd_q.push_back(poll_cmd(c, 1'b1, 16'($urandom), gen_pkt[c],
                                             gen_tick[c]));
                end
                for (int j = 0; j < 4; j++)
                    cmd_q.push_back(map_cmd(bka_pkg::OP_CLEAR, 2'(j), 16'($urandom),
                                            8'($urandom), 16'($urandom)));
                k += bka_pkg::MAP_DEPTH + 11;
            end
            cmd_q.push_back(rand_cmd());
        end
    endtask

    task automatic write_events_enable(input logic val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {bka_pkg::REG_EVENTS_ENABLE, 2'b00};
        pwdata  <= {31'h0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        ev_enable = val;
        n_cfg++;
    endtask

    // sample at the falling edge so the driver's updates have settled
    task automatic wait_drained();
        do @(negedge i_clk);
        while (cmd_q.size() != 0 || in_valid || owed_words.size() != 0);
    endtask

    // input driver
    always @(posedge i_clk) begin
        t_cmd nxt;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                compute_key_words(req);
                n_in++;
            end
            if (!in_valid || o_in_ready) begin
                if (cmd_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                    nxt = cmd_q.pop_front();
                    req      <= nxt;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        t_key_word w;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (o_kind == bka_pkg::KIND_DOWN) n_down++;
                if (o_kind == bka_pkg::KIND_UP)   n_up++;
                if (o_kind == bka_pkg::KIND_DONE) n_done++;
                if (owed_words.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected word: kind %0d key %02h msg %08h",
                                 o_kind, o_key_out, o_message_word);
                end else begin
                    w = owed_words.pop_front();
                    if (o_kind !== w.kind || o_key_out !== w.key ||
                        o_message_word !== w.msg || o_status !== w.status ||
                        o_connected_out !== w.conn || o_last !== w.last) begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch (exp/got): kind %0d/%0d key %02h/%02h ",
                                      "msg %08h/%08h status %0d/%0d conn %0b/%0b last %0b/%0b"},
                                     w.kind, o_kind, w.key, o_key_out, w.msg, o_message_word,
                                     w.status, o_status, w.conn, o_connected_out,
                                     w.last, o_last);
                    end
                end
            end
            out_ready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still owed", cycles,
                     owed_words.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_events_enable(1'b1);
        // directed: edge-only and max-period maps, duplicate add
        cmd_q.push_back(map_cmd(bka_pkg::OP_ADD, 2'd0, 16'h0001, 8'h41, 16'h0000));
        cmd_q.push_back(map_cmd(bka_pkg::OP_ADD, 2'd0, 16'h0001, 8'h42, 16'h0005));
        cmd_q.push_back(map_cmd(bka_pkg::OP_ADD, 2'd0, 16'h8000, 8'hff, 16'hffff));
        cmd_q.push_back(map_cmd(bka_pkg::OP_ADD, 2'd1, 16'h0002, 8'h00, 16'h0020));
        // first poll only records the pad; press at tick 0 fires again next poll
        cmd_q.push_back(poll_cmd(2'd0, 1'b1, 16'h0000, 32'd1, 32'd100));
        cmd_q.push_back(poll_cmd(2'd0, 1'b1, 16'h8001, 32'd2, 32'd0));
        cmd_q.push_back(poll_cmd(2'd0, 1'b1, 16'h8001, 32'd3, 32'd5));
        cmd_q.push_back(poll_cmd(2'd0, 1'b1, 16'hffff, 32'd3, 32'hffff_ffff));
        // release without packet advance, then with it
        cmd_q.push_back(poll_cmd(2'd0, 1'b1, 16'h0000, 32'd3, 32'd20));
        cmd_q.push_back(poll_cmd(2'd0, 1'b1, 16'h0000, 32'd4, 32'd30));
        // repeat period across tick wrap
        cmd_q.push_back(poll_cmd(2'd1, 1'b1, 16'hffff, 32'hffff_ffff, 32'hffff_ffff));
        cmd_q.push_back(poll_cmd(2'd1, 1'b1, 16'h0002, 32'd0, 32'hffff_fff0));
        cmd_q.push_back(poll_cmd(2'd1, 1'b1, 16'h0002, 32'd1, 32'h0000_0008));
        cmd_q.push_back(poll_cmd(2'd1, 1'b1, 16'h0002, 32'd2, 32'h0000_0010));
        // disconnect forgets the pad
        cmd_q.push_back(poll_cmd(2'd1, 1'b0, 16'h0002, 32'd3, 32'h0000_0020));
        cmd_q.push_back(poll_cmd(2'd1, 1'b1, 16'h0002, 32'd4, 32'h0000_0030));
        cmd_q.push_back(map_cmd(bka_pkg::OP_REM_BTN, 2'd0, 16'h8000, 8'($urandom),
                                16'($urandom)));
        cmd_q.push_back(map_cmd(bka_pkg::OP_REM_KEY, 2'd1, 16'($urandom), 8'h00,
                                16'($urandom)));
        cmd_q.push_back(map_cmd(bka_pkg::OP_REM_BTN, 2'd3, 16'h1234, 8'($urandom),
                                16'($urandom)));
        cmd_q.push_back(map_cmd(bka_pkg::OP_CLEAR, 2'd0, 16'($urandom), 8'($urandom),
                                16'($urandom)));
        for (int op = OP_FIRST_UNUSED; op <= OP_LAST_UNUSED; op++)
            cmd_q.push_back(map_cmd(3'(op), 2'($urandom), 16'hffff, 8'hff, 16'hffff));
        cmd_q.push_back(poll_cmd(2'd2, 1'b1, 16'hffff, 32'hffff_ffff, 32'hffff_ffff));
        wait_drained();

        // no idling at all, ticks start just below the wrap
        idle_pct = 0;
        for (int i = 0; i < 4; i++) begin
            gen_tick[i] = 32'hffff_fc00 + $urandom_range(0, 255);
            gen_pkt[i]  = $urandom_range(0, 16);
        end
        queue_random(120, 1'b1);
        wait_drained();

        idle_pct = 13;
        write_events_enable(1'b0);
        queue_random(100, 1'b0);
        wait_drained();

        write_events_enable(1'b1);
        for (int i = 0; i < 4; i++)
            gen_tick[i] = $urandom;
        queue_random(140, 1'b1);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        $display("run: %0d words in, %0d key-down, %0d key-up, %0d done words out",
                 n_in, n_down, n_up, n_done);
        $display("run: %0d table-full adds, %0d duplicate adds, %0d config writes, %0d errors",
                 n_full, n_exists, n_cfg, errors);
        if (errors == 0 && owed_words.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
